// ----- rtl/core/dtsi_pkg.sv -----
// Package for the decimal text to scaled integer block.
// Holds payload structs, controller/datapath interface structs and character codes.
// Used by dtsi_ctrl, dtsi_datapath and decimal_text_to_scaled_int.
`timescale 1ns / 1ps
`default_nettype none

package dtsi_pkg;

  localparam int ACC_BITS_DEF = 256;
  localparam int OUT_BITS     = 256;
  localparam int WORD_BITS    = 64;
  localparam int CNT_W        = 7;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CNT_W-1:0] MAX_DIGITS = 7'd76;
  localparam logic [CNT_W-1:0] CLASS_32_MAX  = 7'd9;
  localparam logic [CNT_W-1:0] CLASS_64_MAX  = 7'd18;
  localparam logic [CNT_W-1:0] CLASS_128_MAX = 7'd38;

  localparam logic [CNT_W-1:0] PRECISION_RST = 7'd76;
  localparam logic [CNT_W-1:0] SCALE_RST     = 7'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_PRECISION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 1'b1;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INT_LONG   = 2'd1,
    ST_OVERFLOW   = 2'd2,
    ST_BAD_SYMBOL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CLS_32  = 2'd0,
    CLS_64  = 2'd1,
    CLS_128 = 2'd2,
    CLS_256 = 2'd3
  } class_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] value_word3;
    logic [WORD_BITS-1:0]        value_word2;
    logic [WORD_BITS-1:0]        value_word1;
    logic [WORD_BITS-1:0]        value_word0;
    logic [1:0]                  status;
    logic [1:0]                  storage_class;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic pad;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic pad_done;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/dtsi_ctrl.sv -----
// Controller state machine of the decimal text to scaled integer block.
// Sequences character intake, zero padding and result hand-off; depends on dtsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtsi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output dtsi_pkg::dp_cmd_t cmd,
  input  dtsi_pkg::dp_sts_t sts
);
  import dtsi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PAD  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_last) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (sts.pad_done) begin
          state_nxt = S_FIN;
        end else begin
          cmd.pad = 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.finish || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/core/dtsi_datapath.sv -----
// Datapath of the decimal text to scaled integer block.
// Holds the configuration registers, the magnitude accumulator with its times-ten
// adder, the parse state and the result register; depends on dtsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtsi_datapath #(
  parameter int ACC_BITS = dtsi_pkg::ACC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dtsi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dtsi_pkg::CNT_W-1:0]       cfg_wdata,
  input  dtsi_pkg::in_item_t               in_data,
  input  dtsi_pkg::dp_cmd_t                cmd,
  output dtsi_pkg::dp_sts_t                sts,
  output dtsi_pkg::out_item_t              out_data
);
  import dtsi_pkg::*;

  localparam int EXT_BITS = ACC_BITS + 4;

  logic [CNT_W-1:0]    precision_r, scale_r;
  logic [ACC_BITS-1:0] mag_r, mag_nxt;
  logic                neg_r, neg_nxt;
  logic                first_r, first_nxt;
  logic                dot_r, dot_nxt;
  logic [CNT_W-1:0]    int_cnt_r, int_cnt_nxt;
  logic [CNT_W-1:0]    frac_cnt_r, frac_cnt_nxt;
  status_t             err_r, err_nxt;
  out_item_t           out_r;

  logic [CNT_W-1:0]    eff_prec, limit;
  logic [3:0]          add_val;
  logic [EXT_BITS-1:0] ext, sum;
  logic                ovf;
  logic [OUT_BITS-1:0] mag_ext, res;
  class_t              cls;

  always_comb begin
    eff_prec = (precision_r > MAX_DIGITS) ? MAX_DIGITS : precision_r;
    limit    = (eff_prec > scale_r) ? (eff_prec - scale_r) : '0;
    add_val  = cmd.pad ? 4'd0 : in_data.ch[3:0];
    ext      = EXT_BITS'(mag_r);
    sum      = (ext << 3) + (ext << 1) + EXT_BITS'(add_val);
    ovf      = |sum[EXT_BITS-1:ACC_BITS-1];
  end

  assign sts.pad_done = (err_r != ST_OK) || (frac_cnt_r >= scale_r);

  always_comb begin
    mag_nxt      = mag_r;
    neg_nxt      = neg_r;
    first_nxt    = first_r;
    dot_nxt      = dot_r;
    int_cnt_nxt  = int_cnt_r;
    frac_cnt_nxt = frac_cnt_r;
    err_nxt      = err_r;
    if (cmd.finish) begin
      mag_nxt      = '0;
      neg_nxt      = 1'b0;
      first_nxt    = 1'b1;
      dot_nxt      = 1'b0;
      int_cnt_nxt  = '0;
      frac_cnt_nxt = '0;
      err_nxt      = ST_OK;
    end else if (cmd.pad) begin
      if (ovf) begin
        err_nxt = ST_OVERFLOW;
      end else begin
        mag_nxt      = sum[ACC_BITS-1:0];
        frac_cnt_nxt = frac_cnt_r + 1'b1;
      end
    end else if (cmd.take) begin
      first_nxt = 1'b0;
      if (err_r == ST_OK && !(dot_r && frac_cnt_r >= scale_r)) begin
        if (in_data.ch == CH_MINUS) begin
          if (first_r) begin
            neg_nxt = 1'b1;
          end else begin
            err_nxt = ST_BAD_SYMBOL;
          end
        end else if (in_data.ch == CH_DOT && !dot_r) begin
          dot_nxt = 1'b1;
        end else if (in_data.ch inside {[CH_ZERO:CH_NINE]}) begin
          if (!dot_r && int_cnt_r >= limit) begin
            err_nxt = ST_INT_LONG;
          end else if (ovf) begin
            err_nxt = ST_OVERFLOW;
          end else begin
            mag_nxt = sum[ACC_BITS-1:0];
            if (dot_r) begin
              frac_cnt_nxt = frac_cnt_r + 1'b1;
            end else begin
              int_cnt_nxt = int_cnt_r + 1'b1;
            end
          end
        end else begin
          err_nxt = ST_BAD_SYMBOL;
        end
      end
    end
  end

  always_comb begin
    mag_ext = OUT_BITS'(mag_r);
    if (err_r != ST_OK) begin
      res = '0;
    end else if (neg_r) begin
      res = ~mag_ext + 1'b1;
    end else begin
      res = mag_ext;
    end
    case (precision_r) inside
      [7'd0:CLASS_32_MAX]:           cls = CLS_32;
      [CLASS_32_MAX+7'd1:CLASS_64_MAX]:  cls = CLS_64;
      [CLASS_64_MAX+7'd1:CLASS_128_MAX]: cls = CLS_128;
      default:                       cls = CLS_256;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      precision_r <= PRECISION_RST;
      scale_r     <= SCALE_RST;
      mag_r       <= '0;
      neg_r       <= 1'b0;
      first_r     <= 1'b1;
      dot_r       <= 1'b0;
      int_cnt_r   <= '0;
      frac_cnt_r  <= '0;
      err_r       <= ST_OK;
    end else begin
      if (cfg_we && cfg_index == CFG_PRECISION) begin
        precision_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_SCALE) begin
        scale_r <= cfg_wdata;
      end
      mag_r      <= mag_nxt;
      neg_r      <= neg_nxt;
      first_r    <= first_nxt;
      dot_r      <= dot_nxt;
      int_cnt_r  <= int_cnt_nxt;
      frac_cnt_r <= frac_cnt_nxt;
      err_r      <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.value_word0   <= res[WORD_BITS-1:0];
      out_r.value_word1   <= res[2*WORD_BITS-1:WORD_BITS];
      out_r.value_word2   <= res[3*WORD_BITS-1:2*WORD_BITS];
      out_r.value_word3   <= res[4*WORD_BITS-1:3*WORD_BITS];
      out_r.status        <= err_r;
      out_r.storage_class <= cls;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ----- rtl/core/decimal_text_to_scaled_int.sv -----
// Top level of the decimal text to scaled integer block.
// Joins dtsi_ctrl and dtsi_datapath; depends on dtsi_pkg.
//
// Usage: the text enters one character per item on the in_ channel, the final
// character flagged by last. An item is taken when in_valid is high and in_stall
// is low. The block parses an optional leading minus, digits and one dot into a
// scaled 256-bit two's complement value and delivers one result item per string
// on the out_ channel, with a status code and the storage width class.
// Characters that are not the last are taken one per cycle, limited by the single
// times-ten adder on the accumulator. After the last one come the zero-padding
// steps (scale minus fractional digits seen, cut short by an error), a check and
// the hand-off, after which out_valid rises. A finished result sits in an output
// register; the block keeps taking the next string's characters while the
// receiver stalls and waits only at the hand-off of the next result. Precision
// and scale are written on the cfg_ channel, which is always ready; the user must
// write them only while the block is idle, which the block does not enforce.
// Reset restores precision 76, scale 0 and an empty string, with no result pending.
`timescale 1ns / 1ps
`default_nettype none

module decimal_text_to_scaled_int #(
  parameter int ACC_BITS = dtsi_pkg::ACC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  dtsi_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output dtsi_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dtsi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dtsi_pkg::CNT_W-1:0]     cfg_wdata
);
  import dtsi_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  dtsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  dtsi_datapath #(
    .ACC_BITS (ACC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.value_word0 == '0 && out_data.value_word1 == '0 &&
      out_data.value_word2 == '0 && out_data.value_word3 == '0)
    else $error("errored result carries a nonzero value");

  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a finishing string");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.take, cmd.pad, cmd.finish}) <= 1)
    else $error("datapath got conflicting commands");

endmodule

`default_nettype wire

// ----- bench/decimal_text_to_scaled_int_test.sv -----
// Self-checking bench for decimal_text_to_scaled_int: drives decimal text one character per
// item, predicts every scaled result in a local model of the parser and compares field by field.
// Depends on dtsi_pkg and the decimal_text_to_scaled_int RTL.
`timescale 1ns / 1ps

module decimal_text_to_scaled_int_test;
  import dtsi_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int SETTINGS_N   = 12;
  localparam int CHARS_PER_SETTING = 40;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]     cfg_wdata;

  logic [CNT_W-1:0] cur_precision;
  logic [CNT_W-1:0] cur_scale;
  logic [255:0]     acc_mag;
  logic             acc_negative;
  logic             at_start;
  logic             dot_seen;
  int               int_digits;
  int               frac_digits;
  status_t          acc_status;
  out_item_t        pending_results[$];

  int mismatch_count;
  int cycle_count = 0;
  int sent_chars;
  int send_gap_pct;
  int stall_pct;
  int stall_hold;

  int precision_set[SETTINGS_N] = '{76, 1, 1, 76, 9, 18, 38, 10, 39, 19, 2, 76};
  int scale_set[SETTINGS_N]     = '{0, 0, 1, 76, 3, 18, 5, 0, 20, 2, 1, 38};

  decimal_text_to_scaled_int u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic int int_digit_limit();
    int eff;
    eff = int'((cur_precision > MAX_DIGITS) ? MAX_DIGITS : cur_precision);
    return (eff > int'(cur_scale)) ? eff - int'(cur_scale) : 0;
  endfunction

  // Returns 1 on overflow of the signed 256-bit range and then leaves the magnitude alone.
  function automatic bit push_digit(input int unsigned d);
    logic [259:0] w;
    w = {4'd0, acc_mag} * 260'd10 + 260'(d);
    if (|w[259:255]) return 1'b1;
    acc_mag = w[255:0];
    return 1'b0;
  endfunction

  task automatic clear_string();
    acc_mag      = '0;
    acc_negative = 1'b0;
    at_start     = 1'b1;
    dot_seen     = 1'b0;
    int_digits   = 0;
    frac_digits  = 0;
    acc_status   = ST_OK;
  endtask

  task automatic predict_char(input logic [7:0] c, input logic l);
    int           limit;
    bit           first;
    logic [255:0] val;
    out_item_t    res;
    limit = int_digit_limit();
    first = at_start;
    at_start = 1'b0;
    if (acc_status == ST_OK && !(dot_seen && frac_digits >= cur_scale)) begin
      if (c == CH_MINUS) begin
        if (first) acc_negative = 1'b1;
        else acc_status = ST_BAD_SYMBOL;
      end else if (c == CH_DOT && !dot_seen) begin
        dot_seen = 1'b1;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        if (!dot_seen && int_digits >= limit) acc_status = ST_INT_LONG;
        else if (push_digit(32'(c - CH_ZERO))) acc_status = ST_OVERFLOW;
        else if (dot_seen) frac_digits++;
        else int_digits++;
      end else begin
        acc_status = ST_BAD_SYMBOL;
      end
    end
    if (l) begin
      if (acc_status == ST_OK) begin
        for (int i = frac_digits; i < cur_scale; i++) begin
          if (push_digit(0)) begin
            acc_status = ST_OVERFLOW;
            break;
          end
        end
      end
      val = '0;
      if (acc_status == ST_OK) val = acc_negative ? -acc_mag : acc_mag;
      res.value_word0 = val[63:0];
      res.value_word1 = val[127:64];
      res.value_word2 = val[191:128];
      res.value_word3 = val[255:192];
      res.status      = acc_status;
      if (cur_precision <= CLASS_32_MAX) res.storage_class = CLS_32;
      else if (cur_precision <= CLASS_64_MAX) res.storage_class = CLS_64;
      else if (cur_precision <= CLASS_128_MAX) res.storage_class = CLS_128;
      else res.storage_class = CLS_256;
      pending_results.push_back(res);
      clear_string();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [255:0] got,
                                 input logic [255:0] want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending, word0", 256'(out_data.value_word0), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.value_word0 !== want.value_word0)
          report_mismatch("value_word0", 256'(out_data.value_word0),
                          256'(want.value_word0));
        if (out_data.value_word1 !== want.value_word1)
          report_mismatch("value_word1", 256'(out_data.value_word1),
                          256'(want.value_word1));
        if (out_data.value_word2 !== want.value_word2)
          report_mismatch("value_word2", 256'(out_data.value_word2),
                          256'(want.value_word2));
        if (out_data.value_word3 !== want.value_word3)
          report_mismatch("value_word3", 256'(out_data.value_word3),
                          256'(want.value_word3));
        if (out_data.status !== want.status)
          report_mismatch("status", 256'(out_data.status), 256'(want.status));
        if (out_data.storage_class !== want.storage_class)
          report_mismatch("storage_class", 256'(out_data.storage_class),
                          256'(want.storage_class));
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with in_valid still high.
  task automatic send_char(input logic [7:0] c, input logic l);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{ch: c, last: l};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_char(c, l);
    sent_chars++;
    @(negedge clk);
  endtask

  task automatic send_text(input logic [7:0] text[$]);
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic send_word(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_PRECISION) cur_precision = val;
    else cur_scale = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input int prec, input int scl);
    wait_for_results();
    write_reg(CFG_PRECISION, CNT_W'(prec));
    write_reg(CFG_SCALE, CNT_W'(scl));
  endtask

  // Mostly well-formed numbers with random digits, some with one bad character put in,
  // and some pure byte noise.
  task automatic build_string(output logic [7:0] text[$]);
    int         limit;
    int         n_int;
    int         n_frac;
    int         kind;
    logic [7:0] bad;
    text  = {};
    limit = int_digit_limit();
    kind  = $urandom_range(99);
    if (kind >= 85) begin
      repeat ($urandom_range(1, 5)) text.push_back(8'($urandom_range(255)));
      return;
    end
    if ($urandom_range(1)) text.push_back(CH_MINUS);
    case ($urandom_range(9))
      0: n_int = limit;
      1: n_int = limit + 1;
      default: n_int = $urandom_range(0, (limit < 4) ? limit : 4);
    endcase
    repeat (n_int) text.push_back(8'(CH_ZERO + $urandom_range(9)));
    if ($urandom_range(9) < 7) begin
      text.push_back(CH_DOT);
      case ($urandom_range(9))
        0: n_frac = int'(cur_scale);
        1: n_frac = int'(cur_scale) + $urandom_range(1, 3);
        default: n_frac = $urandom_range(0, (cur_scale < 3) ? cur_scale : 3);
      endcase
      for (int i = 0; i < n_frac; i++) begin
        if (i >= cur_scale && $urandom_range(1)) text.push_back(8'($urandom_range(255)));
        else text.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
    end
    if (text.size() == 0) text.push_back(8'(CH_ZERO + $urandom_range(9)));
    if (kind >= 70) begin
      case ($urandom_range(2))
        0: bad = 8'($urandom_range(255));
        1: bad = CH_DOT;
        default: bad = CH_MINUS;
      endcase
      text.insert($urandom_range(text.size()), bad);
    end
  endtask

  task automatic test_special_cases();
    send_word("-");
    send_char(8'hff, 1'b1);
    send_char(8'h00, 1'b1);
    send_word("1-2");
    set_config(4, 2);
    send_word("12");
    send_word("123");
    send_word("1.2.3");
    send_word(".57x-");
    send_word("-3.1");
  endtask

  task automatic test_random_strings(input int gap_pct, input int hold_pct);
    logic [7:0] text[$];
    int         start;
    send_gap_pct = gap_pct;
    stall_pct    = hold_pct;
    for (int k = 0; k < SETTINGS_N; k++) begin
      set_config(precision_set[k], scale_set[k]);
      start = sent_chars;
      while (sent_chars - start < CHARS_PER_SETTING) begin
        build_string(text);
        send_text(text);
      end
    end
  endtask

  task automatic test_backpressure();
    logic [7:0] text[$];
    set_config(76, 2);
    send_gap_pct = 0;
    stall_pct    = 0;
    @(posedge clk);
    stall_hold = 300;
    @(negedge clk);
    repeat (8) begin
      build_string(text);
      send_text(text);
    end
    wait_for_results();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_PRECISION;
    cfg_wdata      = '0;
    send_gap_pct   = 0;
    stall_pct      = 0;
    stall_hold     = 0;
    mismatch_count = 0;
    sent_chars     = 0;
    cur_precision  = PRECISION_RST;
    cur_scale      = SCALE_RST;
    clear_string();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_special_cases();
    test_random_strings(37, 57);
    test_random_strings(57, 37);
    test_random_strings(0, 0);
    test_backpressure();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/dtsi_pkg.sv
rtl/core/dtsi_ctrl.sv
rtl/core/dtsi_datapath.sv
rtl/core/decimal_text_to_scaled_int.sv
bench/decimal_text_to_scaled_int_test.sv
